FILE: design/cwpn_pkg.sv
// Package for the complex weight pair normalizer: widths, payload structs
// and the per-stage item carried along the divider cell row. No dependencies.
package cwpn_pkg;

  localparam int FRAC_BITS = 24;
  localparam int WW        = 32;               // weight part width
  localparam int PW        = 2 * WW;           // product / magnitude width
  localparam int QB        = WW + 2;           // quotient bits incl. round bit
  localparam int LANES     = 4;
  localparam int XW        = PW + FRAC_BITS + 1;
  localparam logic [WW-1:0] ONE_FX = WW'(1) << FRAC_BITS;
  localparam logic [WW-1:0] POS_MAX = {1'b0, {(WW-1){1'b1}}};
  localparam logic [WW-1:0] NEG_MAX = {1'b1, {(WW-1){1'b0}}};

  typedef struct packed {
    logic signed [WW-1:0] first_real;
    logic signed [WW-1:0] first_imag;
    logic signed [WW-1:0] second_real;
    logic signed [WW-1:0] second_imag;
  } in_t;

  typedef struct packed {
    logic signed [WW-1:0] norm_first_real;
    logic signed [WW-1:0] norm_first_imag;
    logic signed [WW-1:0] norm_second_real;
    logic signed [WW-1:0] norm_second_imag;
    logic signed [WW-1:0] coef_real;
    logic signed [WW-1:0] coef_imag;
    logic                 saturated;
  } out_t;

  // One quotient lane: sign, partial remainder, dividend bits still to
  // shift in, quotient bits so far, and the early overflow flag.
  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [PW-1:0] rem;
    logic [QB-1:0] low;
    logic [QB-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [PW-1:0]        den;
    logic                 nz;
    logic [WW-1:0]        cr;
    logic [WW-1:0]        ci;
    div_lane_t [LANES-1:0] lane;
  } div_item_t;

endpackage

FILE: design/cwpn_front.sv
// Front pipeline: squared magnitudes, coefficient pick, cross products and
// divider setup. Depends on cwpn_pkg.
module cwpn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  cwpn_pkg::in_t     data_i,
  input  logic [31:0]       eps_sq,
  output logic              vld_o,
  output cwpn_pkg::div_item_t item_o
);
  import cwpn_pkg::*;

  logic [5:0] vld_r;

  // stage 1: squares
  in_t           s1_in_r;
  logic [PW-1:0] s1_sq_r [4];
  // stage 2: magnitudes
  in_t           s2_in_r;
  logic [PW-1:0] s2_n1_r, s2_n2_r;
  // stage 3: pick
  in_t                  s3_in_r;
  logic signed [WW-1:0] s3_cr_r, s3_ci_r;
  logic [PW-1:0]        s3_n_r;
  logic                 s3_nz_r;
  logic                 pick2;
  logic [PW-1:0]        n_sel;
  // stage 4: cross products
  logic signed [PW-1:0] s4_p_r [8];
  logic [PW-1:0]        s4_n_r;
  logic                 s4_nz_r;
  logic [WW-1:0]        s4_cr_r, s4_ci_r;
  // stage 5: numerators
  logic                 s5_neg_r [LANES];
  logic [PW-1:0]        s5_mag_r [LANES];
  logic [PW-1:0]        s5_n_r;
  logic                 s5_nz_r;
  logic [WW-1:0]        s5_cr_r, s5_ci_r;
  logic signed [PW:0]   sum [LANES];
  // stage 6
  div_item_t            s6_r, s6_nxt;
  logic [XW-1:0]        xv [LANES];
  logic [PW-1:0]        hi [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_in_r   <= data_i;
      s1_sq_r[0] <= PW'(data_i.first_real * data_i.first_real);
      s1_sq_r[1] <= PW'(data_i.first_imag * data_i.first_imag);
      s1_sq_r[2] <= PW'(data_i.second_real * data_i.second_real);
      s1_sq_r[3] <= PW'(data_i.second_imag * data_i.second_imag);

      s2_in_r <= s1_in_r;
      s2_n1_r <= s1_sq_r[0] + s1_sq_r[1];
      s2_n2_r <= s1_sq_r[2] + s1_sq_r[3];

      s3_in_r <= s2_in_r;
      s3_cr_r <= pick2 ? s2_in_r.second_real : s2_in_r.first_real;
      s3_ci_r <= pick2 ? s2_in_r.second_imag : s2_in_r.first_imag;
      s3_n_r  <= n_sel;
      s3_nz_r <= n_sel <= PW'(eps_sq);

      s4_p_r[0] <= s3_in_r.first_real  * s3_cr_r;
      s4_p_r[1] <= s3_in_r.first_imag  * s3_ci_r;
      s4_p_r[2] <= s3_in_r.first_imag  * s3_cr_r;
      s4_p_r[3] <= s3_in_r.first_real  * s3_ci_r;
      s4_p_r[4] <= s3_in_r.second_real * s3_cr_r;
      s4_p_r[5] <= s3_in_r.second_imag * s3_ci_r;
      s4_p_r[6] <= s3_in_r.second_imag * s3_cr_r;
      s4_p_r[7] <= s3_in_r.second_real * s3_ci_r;
      s4_n_r    <= s3_n_r;
      s4_nz_r   <= s3_nz_r;
      s4_cr_r   <= s3_cr_r;
      s4_ci_r   <= s3_ci_r;

      for (int l = 0; l < LANES; l++) begin
        s5_neg_r[l] <= sum[l][PW];
        s5_mag_r[l] <= sum[l][PW] ? PW'(-sum[l]) : sum[l][PW-1:0];
      end
      s5_n_r  <= s4_n_r;
      s5_nz_r <= s4_nz_r;
      s5_cr_r <= s4_cr_r;
      s5_ci_r <= s4_ci_r;

      s6_r <= s6_nxt;
    end
  end

  always_comb begin
    pick2 = (s2_n2_r > s2_n1_r) && ((s2_n2_r - s2_n1_r) > PW'(eps_sq));
    n_sel = pick2 ? s2_n2_r : s2_n1_r;
    sum[0] = (PW+1)'(s4_p_r[0]) + (PW+1)'(s4_p_r[1]);
    sum[1] = (PW+1)'(s4_p_r[2]) - (PW+1)'(s4_p_r[3]);
    sum[2] = (PW+1)'(s4_p_r[4]) + (PW+1)'(s4_p_r[5]);
    sum[3] = (PW+1)'(s4_p_r[6]) - (PW+1)'(s4_p_r[7]);
  end

  // Scale the numerator by two to the FRAC_BITS+1; the top part must stay
  // below the divisor or the quotient cannot fit.
  always_comb begin
    s6_nxt.den = s5_n_r;
    s6_nxt.nz  = s5_nz_r;
    s6_nxt.cr  = s5_cr_r;
    s6_nxt.ci  = s5_ci_r;
    for (int l = 0; l < LANES; l++) begin
      xv[l] = {s5_mag_r[l], (FRAC_BITS + 1)'(0)};
      hi[l] = PW'(xv[l][XW-1:QB]);
      s6_nxt.lane[l].neg = s5_neg_r[l];
      s6_nxt.lane[l].ovf = hi[l] >= s5_n_r;
      s6_nxt.lane[l].rem = (hi[l] >= s5_n_r) ? '0 : hi[l];
      s6_nxt.lane[l].low = xv[l][QB-1:0];
      s6_nxt.lane[l].quo = '0;
    end
  end

  assign vld_o  = vld_r[5];
  assign item_o = s6_r;

endmodule

FILE: design/cwpn_div_cell.sv
// One restoring-division cell: produces one quotient bit per lane and
// hands the item to the next cell. Depends on cwpn_pkg.
module cwpn_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  cwpn_pkg::div_item_t item_i,
  output logic                vld_o,
  output cwpn_pkg::div_item_t item_o
);
  import cwpn_pkg::*;

  logic      vld_r;
  div_item_t item_r, item_nxt;
  logic [PW:0] shifted [LANES];
  logic [PW:0] trial   [LANES];

  always_comb begin
    item_nxt = item_i;
    for (int l = 0; l < LANES; l++) begin
      shifted[l] = {item_i.lane[l].rem, item_i.lane[l].low[QB-1]};
      trial[l]   = shifted[l] - {1'b0, item_i.den};
      item_nxt.lane[l].low = {item_i.lane[l].low[QB-2:0], 1'b0};
      if (!trial[l][PW]) begin
        item_nxt.lane[l].rem = trial[l][PW-1:0];
        item_nxt.lane[l].quo = {item_i.lane[l].quo[QB-2:0], 1'b1};
      end else begin
        item_nxt.lane[l].rem = shifted[l][PW-1:0];
        item_nxt.lane[l].quo = {item_i.lane[l].quo[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

FILE: design/complex_weight_pair_normalizer_top.sv
// Top level of the complex weight pair normalizer: config register, front
// pipeline, divider cell row and rounding output stage. Depends on cwpn_pkg.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_data   (in_t)
//   out_    | output    | out_valid / out_ready | out_data  (out_t)
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_data  (eps_sq, 32 bits)
//
// One transaction per cycle sustained while the output is taken; the pipeline is six front
// stages, one divider cell per quotient bit (34) and the output register.
// Synchronous active-low reset clears the valid bits and sets eps_sq to 28147.
// The pipeline stalls as a whole only when its last cell holds a result and
// the output register is full and not taken; bubbles stay in place while stalled.
module complex_weight_pair_normalizer_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cwpn_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cwpn_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);
  import cwpn_pkg::*;

  logic [31:0] eps_r;
  logic        en;
  logic        out_valid_r;
  out_t        out_r, out_nxt;
  logic        sat_any;

  logic      vld   [QB+1];
  div_item_t items [QB+1];

  logic [QB:0]   qr [LANES];
  logic [WW-1:0] val [LANES];
  logic          sat [LANES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= 32'd28147;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_data;
    end
  end

  // Hold everything only when the last cell cannot drain.
  assign en       = !(vld[QB] && out_valid_r && !out_ready);
  assign in_ready = en;

  cwpn_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid && in_ready),
    .data_i (in_data),
    .eps_sq (eps_r),
    .vld_o  (vld[0]),
    .item_o (items[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_cell
    cwpn_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld[g]),
      .item_i (items[g]),
      .vld_o  (vld[g+1]),
      .item_o (items[g+1])
    );
  end

  // Round half away from zero on the magnitude, then saturate by sign.
  always_comb begin
    sat_any = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      qr[l] = ((QB+1)'(items[QB].lane[l].quo) + (QB+1)'(1)) >> 1;
      if (items[QB].lane[l].neg) begin
        sat[l] = items[QB].lane[l].ovf || (qr[l] > (QB+1)'(NEG_MAX));
        val[l] = sat[l] ? NEG_MAX : WW'((QB+1)'(0) - qr[l]);
      end else begin
        sat[l] = items[QB].lane[l].ovf || (qr[l] > (QB+1)'(POS_MAX));
        val[l] = sat[l] ? POS_MAX : WW'(qr[l]);
      end
      sat_any = sat_any | sat[l];
    end
    if (items[QB].nz) begin
      out_nxt.norm_first_real  = '0;
      out_nxt.norm_first_imag  = '0;
      out_nxt.norm_second_real = '0;
      out_nxt.norm_second_imag = '0;
      out_nxt.coef_real        = ONE_FX;
      out_nxt.coef_imag        = '0;
      out_nxt.saturated        = 1'b0;
    end else begin
      out_nxt.norm_first_real  = val[0];
      out_nxt.norm_first_imag  = val[1];
      out_nxt.norm_second_real = val[2];
      out_nxt.norm_second_imag = val[3];
      out_nxt.coef_real        = items[QB].cr;
      out_nxt.coef_imag        = items[QB].ci;
      out_nxt.saturated        = sat_any;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[QB] || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[QB]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
